// ===== rtl/stq_pkg.sv =====
// Shared constants, types and helpers for the sorted timer task queue.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FIRED = 2'd1;
    localparam logic [1:0] ST_IDLE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] due_time;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] task_id;
        logic [31:0] fired_due;
        logic [4:0]  pending;
    } t_result;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] id;
    } t_entry;

    // count reported modulo 32
    function automatic logic [4:0] pend5(input logic [CW-1:0] c);
        logic [CW+4:0] e;
        e = {5'b0, c};
        return e[4:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stq_in_if.sv =====
// Input channel of the timer task queue: valid/ready plus one request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stq_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] due_time;
    logic [31:0] now_time;

    modport source (output valid, output op, output due_time, output now_time, input ready);
    modport sink   (input valid, input op, input due_time, input now_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/stq_out_if.sv =====
// Result channel of the timer task queue: valid/ready plus one result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] task_id;
    logic [31:0] fired_due;
    logic [4:0]  pending;

    modport source (output valid, output status, output task_id, output fired_due,
                    output pending, input ready);
    modport sink   (input valid, input status, input task_id, input fired_due,
                    input pending, output ready);
endinterface

`default_nettype wire

// ===== rtl/stq_engine.sv =====
// Queue engine: circular entry memory plus the insert/fire sequencer.
// Depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_engine import stq_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_req    i_req,
    output logic         o_res_valid,
    input  wire logic    i_res_ready,
    output t_result      o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_TICK_CMP,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_next_id, n_next_id;
    logic [AW-1:0] r_pos, n_pos;
    logic [31:0]   r_due, n_due;
    logic [31:0]   r_now, n_now;
    logic [31:0]   r_id, n_id;
    t_result       r_res, n_res;

    t_entry        r_mem [DEPTH];
    t_entry        r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // logical slot k -> physical address, wrapping at DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] k);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, k};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_pos     = r_pos;
        n_due     = r_due;
        n_now     = r_now;
        n_id      = r_id;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '{due: r_due, id: r_id};
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.op == OP_ADD) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res   = '{status: ST_FULL, task_id: '0, fired_due: '0,
                                        pending: pend5(r_count)};
                            n_state = S_DONE;
                        end else begin
                            n_id      = r_next_id;
                            n_next_id = r_next_id + 32'd1;
                            n_due     = i_req.due_time;
                            if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_head;
                                mem_wdata = '{due: i_req.due_time, id: r_next_id};
                                n_count   = r_count + CW'(1);
                                n_res     = '{status: ST_ADDED, task_id: r_next_id,
                                              fired_due: '0,
                                              pending: pend5(r_count + CW'(1))};
                                n_state   = S_DONE;
                            end else begin
                                n_pos     = AW'(r_count);
                                mem_re    = 1'b1;
                                mem_raddr = phys(r_head, AW'(r_count - CW'(1)));
                                n_state   = S_INS_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res   = '{status: ST_IDLE, task_id: '0, fired_due: '0,
                                        pending: pend5(r_count)};
                            n_state = S_DONE;
                        end else begin
                            n_now     = i_req.now_time;
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                            n_state   = S_TICK_CMP;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                // r_rdata holds logical slot r_pos-1
                if (r_rdata.due > r_due) begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(r_head, r_pos);
                    mem_wdata = r_rdata;
                    n_pos     = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, r_pos - AW'(2));
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(r_head, r_pos);
                    n_count   = r_count + CW'(1);
                    n_res     = '{status: ST_ADDED, task_id: r_id, fired_due: '0,
                                  pending: pend5(r_count + CW'(1))};
                    n_state   = S_DONE;
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_head;
                n_count   = r_count + CW'(1);
                n_res     = '{status: ST_ADDED, task_id: r_id, fired_due: '0,
                              pending: pend5(r_count + CW'(1))};
                n_state   = S_DONE;
            end
            S_TICK_CMP: begin
                if (r_now > r_rdata.due) begin
                    n_head  = phys(r_head, AW'(1));
                    n_count = r_count - CW'(1);
                    n_res   = '{status: ST_FIRED, task_id: r_rdata.id,
                                fired_due: r_rdata.due,
                                pending: pend5(r_count - CW'(1))};
                end else begin
                    n_res   = '{status: ST_IDLE, task_id: '0, fired_due: '0,
                                pending: pend5(r_count)};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_next_id <= 32'd1;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
        r_pos <= n_pos;
        r_due <= n_due;
        r_now <= n_now;
        r_id  <= n_id;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_task_queue_core.sv =====
// Top level of the sorted timer task queue: engine plus result register.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_engine.
//
// Holds up to DEPTH pending timer tasks in due-time order, earliest first.
// An add transfer (op 0) gives the task the next identifier (1 after reset,
// wrapping at 32 bits) and slots it in after every queued task with an equal
// or earlier due time; a full queue refuses it with status 3 and burns no
// identifier. A tick transfer (op 1) fires the head when now_time is strictly
// later than its due time, at most one task per tick. Each input transfer
// yields exactly one result transfer. The entries live in one circular memory
// with a single registered read port. An add walks down from the tail, moving
// each later-due entry up one slot by a read-compare-write step, then writes
// the new task into the freed slot. Firing only advances the head pointer. A
// finished result sits in the output register, so the next input transfer is
// taken while the sink stalls. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_task_queue_core import stq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out
);

    t_req    eng_req;
    logic    eng_req_ready;
    logic    eng_res_valid;
    logic    eng_res_ready;
    t_result eng_res;

    logic    r_out_valid;
    t_result r_out;

    assign eng_req = '{op: i_in.op, due_time: i_in.due_time, now_time: i_in.now_time};

    stq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in.valid),
        .o_req_ready (eng_req_ready),
        .i_req       (eng_req),
        .o_res_valid (eng_res_valid),
        .i_res_ready (eng_res_ready),
        .o_res       (eng_res)
    );

    assign i_in.ready = eng_req_ready;

    // output register: loads when empty or being drained this cycle
    assign eng_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_ready) begin
            r_out_valid <= eng_res_valid;
        end
        if (eng_res_ready && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out.status;
    assign o_out.task_id   = r_out.task_id;
    assign o_out.fired_due = r_out.fired_due;
    assign o_out.pending   = r_out.pending;

endmodule

`default_nettype wire

// ===== rtl/stq_checker.sv =====
// Port-level assertions for the sorted timer task queue, bound to the top.
// Depends on stq_pkg and sorted_timer_task_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module stq_checker import stq_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_task_id,
    input wire logic [31:0] i_fired_due,
    input wire logic [4:0]  i_pending
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_task_id) && $stable(i_status))
        else $error("result changed while stalled");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_pending == pend5(CW'(DEPTH)))
        else $error("full refusal with queue not full");

    a_zero_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_IDLE || i_status == ST_FULL)
        |-> i_task_id == 32'd0 && i_fired_due == 32'd0)
        else $error("non-zero id or due on idle or full result");

    a_added_due : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_ADDED |-> i_fired_due == 32'd0)
        else $error("added result carries a due time");

endmodule

bind sorted_timer_task_queue_core stq_checker u_stq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_task_id   (o_out.task_id),
    .i_fired_due (o_out.fired_due),
    .i_pending   (o_out.pending)
);

`default_nettype wire

// ===== verif/stq_tracker_pkg.sv =====
// Result tracker for the sorted timer task queue: mirrors the queue order,
// identifier counter and fill, and checks each result against its prediction.
// Depends on stq_pkg.
`timescale 1ns / 1ps

package stq_tracker_pkg;
    import stq_pkg::*;

    class timer_queue_tracker;
        t_entry      model_tasks[$];
        logic [31:0] model_next_id;
        t_result     awaited_outcomes[$];
        int          errors;

        function new();
            model_next_id = 32'd1;
            errors        = 0;
        endfunction

        function int outstanding();
            return awaited_outcomes.size();
        endfunction

        function int queued_tasks();
            return model_tasks.size();
        endfunction

        // One step of the queue: ordered insert after equal dues, or head fire.
        function t_result predict_outcome(t_req req);
            t_result     res;
            int          pos;
            logic [31:0] cnt;
            res = '0;
            if (req.op == OP_ADD) begin
                if (model_tasks.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_tasks.size() && model_tasks[pos].due <= req.due_time)
                        pos++;
                    model_tasks.insert(pos, '{due: req.due_time, id: model_next_id});
                    res.status    = ST_ADDED;
                    res.task_id   = model_next_id;
                    model_next_id = model_next_id + 32'd1;
                end
            end else begin
                if (model_tasks.size() > 0 && req.now_time > model_tasks[0].due) begin
                    res.status    = ST_FIRED;
                    res.task_id   = model_tasks[0].id;
                    res.fired_due = model_tasks[0].due;
                    void'(model_tasks.pop_front());
                end else begin
                    res.status = ST_IDLE;
                end
            end
            cnt         = model_tasks.size();
            res.pending = cnt[4:0];
            return res;
        endfunction

        function void note_request(t_req req);
            awaited_outcomes.insert(awaited_outcomes.size(), predict_outcome(req));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_outcomes.size() == 0) begin
                errors++;
                $error("result with nothing awaited: status %0d task_id %0h",
                       got.status, got.task_id);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.task_id !== want.task_id) begin
                errors++;
                $error("task_id: expected %0h, got %0h", want.task_id, got.task_id);
            end
            if (got.fired_due !== want.fired_due) begin
                errors++;
                $error("fired_due: expected %0h, got %0h", want.fired_due, got.fired_due);
            end
            if (got.pending !== want.pending) begin
                errors++;
                $error("pending: expected %0d, got %0d", want.pending, got.pending);
            end
        endfunction
    endclass

endpackage

// ===== verif/sorted_timer_task_queue_core_test.sv =====
// Top-level bench for sorted_timer_task_queue_core: directed and random
// add/tick transfers with random idling on both channels.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_tracker_pkg.
`timescale 1ns / 1ps

module sorted_timer_task_queue_core_test;
    import stq_pkg::*;
    import stq_tracker_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SETTLE       = DEPTH + 8;   // margin past the longest insert walk

    logic i_clk;
    logic i_rst_n;
    bit   calm;          // when set, neither side idles
    int   cycles;

    stq_in_if  req_ch();
    stq_out_if res_ch();

    timer_queue_tracker tracker = new();

    sorted_timer_task_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: anything stuck ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen.status    = res_ch.status;
            seen.task_id   = res_ch.task_id;
            seen.fired_due = res_ch.fired_due;
            seen.pending   = res_ch.pending;
            tracker.check_result(seen);
        end
    end

    // Result side: a random stall ahead of each result, ready held once raised
    // until the transfer, so valid/ready never toggle twice in one step.
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    // Drive one request. valid is dropped only when a gap follows, so a
    // back-to-back transfer keeps it high with a single update per step.
    // A drain request holds off until every awaited result has come back.
    task automatic send_request(input logic op, input logic [31:0] due,
                                input logic [31:0] now, input int gap,
                                input bit drain_first);
        int hold;
        hold = (drain_first && gap == 0) ? 1 : gap;
        if (hold > 0) begin
            req_ch.valid <= 1'b0;
            while (drain_first && tracker.outstanding() != 0) @(posedge i_clk);
            repeat (hold) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.due_time <= due;
        req_ch.now_time <= now;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        tracker.note_request('{op: op, due_time: due, now_time: now});
    endtask

    initial begin : stimulus
        int          n;
        int          k;
        int          pick;
        bit          filling;
        bit          drain;
        logic        op;
        logic [31:0] due;
        logic [31:0] now;
        logic [31:0] wall;

        calm            = 1'b0;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_ADD;
        req_ch.due_time <= '0;
        req_ch.now_time <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ticks on an empty queue at both time extremes
        send_request(OP_TICK, 32'hFFFF_FFFF, 32'h0000_0000, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h0000_0000, 32'hFFFF_FFFF, draw_wait(), 1'b0);
        // extreme dues, then a tie on 5 that must keep arrival order
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'h1234_5678, draw_wait(), 1'b0);
        send_request(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, draw_wait(), 1'b0);
        send_request(OP_ADD, 32'd5, 32'h0, draw_wait(), 1'b0);
        send_request(OP_ADD, 32'd5, 32'hA5A5_A5A5, draw_wait(), 1'b0);
        // head not yet due when time equals its due, fires once strictly later
        send_request(OP_TICK, 32'hFFFF_FFFF, 32'd0, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h5A5A_5A5A, 32'd1, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h0, 32'd5, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h0, 32'd6, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h0, 32'd6, draw_wait(), 1'b0);
        send_request(OP_TICK, 32'h0, 32'hFFFF_FFFF, draw_wait(), 1'b0);
        // fill with falling dues so each insert walks the whole queue
        for (k = 0; k < DEPTH - 1; k++)
            send_request(OP_ADD, 32'd1000 - k, $urandom, draw_wait(), 1'b0);
        // full queue refuses the add and burns no identifier
        send_request(OP_ADD, $urandom, $urandom, draw_wait(), 1'b0);

        // Random: alternate fill-biased and drain-biased phases around a
        // moving wall clock so the queue swings between empty and full.
        wall    = 32'd2000;
        filling = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                filling = $urandom_range(0, 1);
                calm    = ($urandom_range(0, 3) == 0);
            end
            drain = (n == 600 || n == 1200);
            op    = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? OP_ADD : OP_TICK;
            due   = $urandom;
            now   = $urandom;
            if (op == OP_ADD) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    due = $urandom;
                else if (pick == 1)
                    due = wall;
                else
                    due = wall + $urandom_range(0, 40);
            end else begin
                if ($urandom_range(0, 19) == 0)
                    wall = $urandom;      // jump to a fresh epoch
                else
                    wall = wall + $urandom_range(0, 6);
                now = wall;
            end
            send_request(op, due, now, draw_wait(), drain);
        end
        req_ch.valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
